FILE: hdl/sihc_pkg.sv
// sihc_pkg: shared types, constants and the hash step for the image header checker
// used by sihc_front, sihc_back and state_image_header_check; no dependencies
package sihc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned HDR_BYTES       = 32;
  localparam int unsigned VERSION_W       = 32;
  localparam int unsigned PLEN_W          = 32;
  localparam int unsigned HASH_W          = 64;

  localparam logic [HASH_W-1:0]    FNV_BASIS   = 64'd1469598103934665603;
  localparam logic [VERSION_W-1:0] VERSION_RST = 32'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_CHECKSUM = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    HF_MAGIC    = 2'd0,
    HF_VERSION  = 2'd1,
    HF_LENGTH   = 2'd2,
    HF_CHECKSUM = 2'd3
  } hdr_field_e;

  // one classified byte between front and back
  typedef struct packed {
    logic [7:0]        data;
    logic              hash_en;
    logic              last;
    status_e           pre_status;
    logic [HASH_W-1:0] decl_sum;
    logic [PLEN_W-1:0] plen;
  } mid_t;

  typedef struct packed {
    logic              accepted;
    status_e           status;
    logic [PLEN_W-1:0] payload_length;
    logic [HASH_W-1:0] checksum;
  } res_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h50;
      3'd1: b = 8'h53;
      3'd2: b = 8'h41;
      3'd3: b = 8'h56;
      3'd4: b = 8'h45;
      3'd5: b = 8'h53;
      3'd6: b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // fnv-1a step; the prime is 2^40 + 0x1b3, so the product is a shift-add
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

FILE: hdl/sihc_fifo.sv
// sihc_fifo: small register queue with push/full and pop/empty sides
// generic; no package dependency
module sihc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow push");

endmodule

FILE: hdl/sihc_front.sv
// sihc_front: byte counter, header field checks and length verdict per image
// depends on sihc_pkg; feeds classified bytes into the middle queue
module sihc_front #(
  parameter int unsigned COUNT_WIDTH = sihc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [sihc_pkg::VERSION_W-1:0]     cfg_data_i,
  output logic                               cfg_ready_o,
  input  logic                               xfer_i,
  input  logic [7:0]                         image_byte_i,
  input  logic                               last_byte_i,
  output sihc_pkg::mid_t                     entry_o
);

  import sihc_pkg::*;

  logic [VERSION_W-1:0]   exp_ver_q;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   magic_good_q, magic_good_d;
  logic                   version_good_q, version_good_d;
  logic [HASH_W-1:0]      decl_len_q, decl_len_d;
  logic [HASH_W-1:0]      decl_sum_q, decl_sum_d;
  logic                   in_hdr;
  logic [4:0]             pos;
  logic [HASH_W-1:0]      tot_ext, plen_ext;
  status_e                pre_status;

  assign cfg_ready_o = 1'b1;
  assign pos         = count_q[4:0];
  assign in_hdr      = (count_q < COUNT_WIDTH'(HDR_BYTES));

  always_comb begin
    magic_good_d   = magic_good_q;
    version_good_d = version_good_q;
    decl_len_d     = decl_len_q;
    decl_sum_d     = decl_sum_q;
    if (in_hdr) begin
      unique case (hdr_field_e'(pos[4:3]))
        HF_MAGIC: begin
          if (image_byte_i != magic_byte(pos[2:0])) magic_good_d = 1'b0;
        end
        HF_VERSION: begin
          if (!pos[2] && image_byte_i != exp_ver_q[{pos[1:0], 3'b000} +: 8]) begin
            version_good_d = 1'b0;
          end
        end
        HF_LENGTH: begin
          decl_len_d = decl_len_q | (HASH_W'(image_byte_i) << {pos[2:0], 3'b000});
        end
        HF_CHECKSUM: begin
          decl_sum_d = decl_sum_q | (HASH_W'(image_byte_i) << {pos[2:0], 3'b000});
        end
        default: ;
      endcase
    end
    count_d = (count_q != '1) ? count_q + 1'b1 : count_q;
  end

  assign tot_ext  = HASH_W'(count_d);
  assign plen_ext = tot_ext - HASH_W'(HDR_BYTES);

  always_comb begin
    if (count_d < COUNT_WIDTH'(HDR_BYTES)) begin
      pre_status = ST_SHORT;
    end else if (!magic_good_d) begin
      pre_status = ST_MAGIC;
    end else if (!version_good_d) begin
      pre_status = ST_VERSION;
    end else if (count_d == '1 || decl_len_d != plen_ext) begin
      pre_status = ST_LENGTH;
    end else begin
      pre_status = ST_OK;
    end
  end

  always_comb begin
    entry_o.data       = image_byte_i;
    entry_o.hash_en    = !in_hdr;
    entry_o.last       = last_byte_i;
    entry_o.pre_status = pre_status;
    entry_o.decl_sum   = decl_sum_d;
    entry_o.plen       = plen_ext[PLEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= VERSION_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      exp_ver_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      magic_good_q   <= 1'b1;
      version_good_q <= 1'b1;
      decl_len_q     <= '0;
      decl_sum_q     <= '0;
    end else if (xfer_i) begin
      if (last_byte_i) begin
        count_q        <= '0;
        magic_good_q   <= 1'b1;
        version_good_q <= 1'b1;
        decl_len_q     <= '0;
        decl_sum_q     <= '0;
      end else begin
        count_q        <= count_d;
        magic_good_q   <= magic_good_d;
        version_good_q <= version_good_d;
        decl_len_q     <= decl_len_d;
        decl_sum_q     <= decl_sum_d;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer_i && last_byte_i |=> count_q == '0 && magic_good_q && version_good_q)
    else $error("image state not cleared after last byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer_i && !last_byte_i && count_q != '1 |=> count_q == $past(count_q) + 1'b1)
    else $error("byte count did not advance");

endmodule

FILE: hdl/sihc_back.sv
// sihc_back: fnv-1a style 64-bit hash over payload bytes and final status per image
// depends on sihc_pkg; drains the middle queue, fills the result queue
module sihc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mid_empty_i,
  input  sihc_pkg::mid_t entry_i,
  output logic           mid_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output sihc_pkg::res_t res_o
);

  import sihc_pkg::*;

  logic [HASH_W-1:0] hash_q, hash_d, hash_new;
  status_e           status;

  assign mid_pop_o  = !mid_empty_i && (!entry_i.last || !res_full_i);
  assign res_push_o = mid_pop_o && entry_i.last;
  assign hash_new   = entry_i.hash_en ? fnv_step(hash_q, entry_i.data) : hash_q;

  always_comb begin
    if (entry_i.pre_status != ST_OK) begin
      status = entry_i.pre_status;
    end else if (entry_i.decl_sum != hash_new) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_o.accepted       = (status == ST_OK);
    res_o.status         = status;
    res_o.payload_length = (status == ST_OK) ? entry_i.plen : '0;
    res_o.checksum       = hash_new;
  end

  always_comb begin
    hash_d = hash_q;
    if (mid_pop_o) begin
      hash_d = entry_i.last ? FNV_BASIS : hash_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
    end else begin
      hash_q <= hash_d;
    end
  end

  a_hash_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> hash_q == FNV_BASIS)
    else $error("hash not restarted after image end");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result written into full queue");

endmodule

FILE: hdl/state_image_header_check.sv
// state_image_header_check: top level of the image header checker
// depends on sihc_pkg, sihc_fifo, sihc_front and sihc_back
//
// Takes an image one byte per transfer, header first, last_byte_i set on the
// final byte, and gives one result per image: status, accepted flag, payload
// length and the fnv-1a style 64-bit checksum of the payload. The block
// sustains one byte per clock while the middle queue has room; the hash step
// is a combinational xor and shift-add on the back side. The back takes a
// byte from the middle queue on the cycle after its transfer, unless the result
// queue is full at the image's last byte. Two-entry queues sit between front
// and back and in front of the result ports, so input stalls only when both
// fill. The version register may be written only while no image is in flight.
module state_image_header_check #(
  parameter int unsigned COUNT_WIDTH = sihc_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = sihc_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sihc_pkg::VERSION_W-1:0]     cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         image_byte_i,
  input  logic                               last_byte_i,
  output logic                               empty,
  input  logic                               pop,
  output logic                               accepted_o,
  output logic [2:0]                         status_o,
  output logic [sihc_pkg::PLEN_W-1:0]        payload_length_o,
  output logic [sihc_pkg::HASH_W-1:0]        computed_checksum_o
);

  import sihc_pkg::*;

  mid_t entry_in, entry_out;
  res_t res_in, res_out;
  logic in_xfer, mid_empty, mid_pop, res_full, res_push;

  assign in_xfer = push && !full;

  sihc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .xfer_i       (in_xfer),
    .image_byte_i (image_byte_i),
    .last_byte_i  (last_byte_i),
    .entry_o      (entry_in)
  );

  sihc_fifo #(
    .WIDTH($bits(mid_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (entry_out),
    .empty_o (mid_empty)
  );

  sihc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .entry_i     (entry_out),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  sihc_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign accepted_o          = res_out.accepted;
  assign status_o            = res_out.status;
  assign payload_length_o    = res_out.payload_length;
  assign computed_checksum_o = res_out.checksum;

endmodule
